// ===== rtl/core/utad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package utad_pkg;

	// field widths
	localparam int OP_W    = 3;
	localparam int VAL_W   = 64;
	localparam int CHAR_W  = 8;
	localparam int LEN_W   = 5;
	localparam int NIB_W   = 4;

	// decimal conversion sizes
	localparam int BIN_W      = 32;
	localparam int DEC_DIGITS = 10;
	localparam int BCD_W      = DEC_DIGITS * NIB_W;
	localparam int BIT_CNT_W  = $clog2(BIN_W);
	localparam int DIG_IDX_W  = $clog2(DEC_DIGITS);

	// opcodes
	localparam logic [OP_W-1:0] OP_DEC   = 3'd0;
	localparam logic [OP_W-1:0] OP_HEX8  = 3'd1;
	localparam logic [OP_W-1:0] OP_HEX16 = 3'd2;
	localparam logic [OP_W-1:0] OP_HEX32 = 3'd3;
	localparam logic [OP_W-1:0] OP_HEX64 = 3'd4;

	// character constants
	localparam logic [CHAR_W-1:0] CHR_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CHR_X      = 8'h78;
	localparam logic [CHAR_W-1:0] CHR_ALPHA  = 8'h57;
	localparam logic [NIB_W-1:0]  NIB_TEN    = 4'd10;

	// status of the conversion unit
	typedef struct packed {
		logic busy;
		logic done;
	} utad_bcd_stat_t;

	// lower-case hex character for one nibble
	function automatic logic [CHAR_W-1:0] hex_char(input logic [NIB_W-1:0] nib);
		logic [CHAR_W-1:0] wide;
		wide = {{(CHAR_W-NIB_W){1'b0}}, nib};
		return (nib < NIB_TEN) ? (wide + CHR_ZERO) : (wide + CHR_ALPHA);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/utad_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface utad_in_if;
	import utad_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [VAL_W-1:0]  value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/utad_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface utad_out_if;
	import utad_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] ascii_char;
	logic              is_last;
	logic [LEN_W-1:0]  string_length;

	modport source (output valid, output ascii_char, output is_last,
		output string_length, input ready);
	modport sink   (input valid, input ascii_char, input is_last,
		input string_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/unsigned_to_ascii_dec_hex.sv =====
// decimal: an accepted item is converted serially by shift-add-3 in the bcd
// unit, and the string is then sent from the registered digits, one
// character per cycle while the output is ready
// hex: first character the cycle after transfer
// input is ready only when idle; undefined opcodes are dropped with no output
// async active-low reset returns the sequencer to idle with no output pending
`timescale 1ns / 1ps
`default_nettype none

module unsigned_to_ascii_dec_hex (
	input  wire logic  clk,
	input  wire logic  arst_n,
	utad_in_if.sink    in_ch,
	utad_out_if.source out_ch
);
	import utad_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]           state_q;
	logic [VAL_W-1:0]     data_q;
	logic [LEN_W-1:0]     len_q;
	logic [LEN_W-1:0]     pos_q;
	logic                 hex_q;

	logic                 in_xfer;
	logic                 out_xfer;
	logic                 bcd_start;
	utad_bcd_stat_t       bcd_stat;
	logic [BCD_W-1:0]     bcd;
	logic [DIG_IDX_W-1:0] top;
	logic [LEN_W-1:0]     dec_len;
	logic [LEN_W-1:0]     hex_len;
	logic [LEN_W-1:0]     idx_full;
	logic [VAL_W-1:0]     shifted;
	logic [NIB_W-1:0]     nib;

	assign in_xfer   = in_ch.valid && in_ch.ready;
	assign out_xfer  = out_ch.valid && out_ch.ready;
	assign bcd_start = in_xfer && (in_ch.opcode == OP_DEC);

	utad_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.bin    (in_ch.value[BIN_W-1:0]),
		.stat   (bcd_stat),
		.bcd    (bcd)
	);

	// highest nonzero decimal digit, zero gives one digit
	always_comb begin
		top = '0;
		for (int d = 0; d < DEC_DIGITS; d++) begin
			if (bcd[d*NIB_W +: NIB_W] != '0) top = DIG_IDX_W'(d);
		end
		dec_len = LEN_W'(top) + 1'b1;
	end

	// "0x" plus 2, 4, 8 or 16 digits
	assign hex_len = (LEN_W'(1) << in_ch.opcode) + LEN_W'(2);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					pos_q <= '0;
					if (in_xfer) begin
						if (in_ch.opcode == OP_DEC) begin
							state_q <= ST_CONV;
						end else if (in_ch.opcode == OP_HEX8 || in_ch.opcode == OP_HEX16
							|| in_ch.opcode == OP_HEX32 || in_ch.opcode == OP_HEX64) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_CONV: begin
					if (bcd_stat.done) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_xfer) begin
						if (pos_q == len_q - 1'b1) begin
							state_q <= ST_IDLE;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// string payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_xfer) begin
			data_q <= in_ch.value;
			len_q  <= hex_len;
			hex_q  <= (in_ch.opcode != OP_DEC);
		end else if (state_q == ST_CONV && bcd_stat.done) begin
			data_q <= {{(VAL_W-BCD_W){1'b0}}, bcd};
			len_q  <= dec_len;
		end
	end

	// digit select, most significant first
	assign idx_full = len_q - 1'b1 - pos_q;
	assign shifted  = data_q >> {idx_full[NIB_W-1:0], 2'b00};
	assign nib      = shifted[NIB_W-1:0];

	always_comb begin
		if (hex_q && pos_q == LEN_W'(0)) begin
			out_ch.ascii_char = CHR_ZERO;
		end else if (hex_q && pos_q == LEN_W'(1)) begin
			out_ch.ascii_char = CHR_X;
		end else if (hex_q) begin
			out_ch.ascii_char = hex_char(nib);
		end else begin
			out_ch.ascii_char = {{(CHAR_W-NIB_W){1'b0}}, nib} + CHR_ZERO;
		end
	end

	assign out_ch.valid         = (state_q == ST_EMIT);
	assign out_ch.is_last       = (pos_q == len_q - 1'b1);
	assign out_ch.string_length = len_q;
	assign in_ch.ready          = (state_q == ST_IDLE);

	// checks
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> pos_q < len_q)
		else $error("character position beyond string length");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("input ready while a string is being sent");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && out_ch.is_last) |=> !out_ch.valid && in_ch.ready)
		else $error("string continues after last character");

	a_done_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		bcd_stat.done |-> state_q == ST_CONV)
		else $error("conversion finished outside conversion state");

endmodule

`default_nettype wire

// ===== rtl/core/utad_bcd.sv =====
`timescale 1ns / 1ps
`default_nettype none

module utad_bcd (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [utad_pkg::BIN_W-1:0] bin,
	output utad_pkg::utad_bcd_stat_t     stat,
	output logic [utad_pkg::BCD_W-1:0]   bcd
);
	import utad_pkg::*;

	logic [BIN_W-1:0]     shift_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BCD_W-1:0]     adj;
	logic [BIT_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int d = 0; d < DEC_DIGITS; d++) begin
			adj[d*NIB_W +: NIB_W] = (bcd_q[d*NIB_W +: NIB_W] >= 4'd5) ?
				(bcd_q[d*NIB_W +: NIB_W] + 4'd3) : bcd_q[d*NIB_W +: NIB_W];
		end
	end

	// sequencer control, one binary bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == BIT_CNT_W'(BIN_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift datapath
	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= bin;
			bcd_q   <= '0;
		end else if (run_q) begin
			bcd_q   <= {adj[BCD_W-2:0], shift_q[BIN_W-1]};
			shift_q <= {shift_q[BIN_W-2:0], 1'b0};
		end
	end

	assign stat.busy = run_q;
	assign stat.done = done_q;
	assign bcd       = bcd_q;

endmodule

`default_nettype wire
